FILE: hdl/tsa_pkg.sv
// Shared types and constants for the tensor slice scatter addresser.
// Used by tsa_setup and tensor_slice_scatter_addresser; no dependencies.
package tsa_pkg;

  localparam int REG_BITS     = 64;
  localparam int IDX_BITS     = 64;
  localparam int ELEM_PORT_W  = 64;
  localparam int RANK_BITS    = 3;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RANK        = 3'd0,
    CFG_SLICE_SHAPE = 3'd1,
    CFG_FULL_SHAPE  = 3'd2,
    CFG_OFFSET      = 3'd3,
    CFG_EXTENT      = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic busy;
    logic cfg_ok;
  } setup_status_t;

endpackage

FILE: hdl/tensor_slice_scatter_addresser.sv
// An accepted input beat's result is registered in the output stage for m_axis.
// Throughput: one beat per cycle while setup is idle and the output drains; a
// two-entry output stage keeps s_axis_tready high while one result waits. After
// reset and after every register write, a setup pass runs with s_axis_tready low.
// Reset (synchronous) restores register defaults and clears the multi-index.
// Depends on tsa_pkg and tsa_setup.
module tensor_slice_scatter_addresser #(
  parameter int MAX_RANK  = 4,
  parameter int DIM_BITS  = 16,
  parameter int ELEM_BITS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tsa_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [tsa_pkg::REG_BITS-1:0]        cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [tsa_pkg::ELEM_PORT_W-1:0]     s_axis_tdata,   // elem_value
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [127:0]                        m_axis_tdata,   // dest_index, dest_value
  output logic [1:0]                          m_axis_tuser,   // write_enable, config_error
  output logic                                m_axis_tlast    // tensor_last
);

  localparam logic [63:0] ELEM_MASK = (64'd1 << ELEM_BITS) - 64'd1;

  typedef struct packed {
    logic [tsa_pkg::IDX_BITS-1:0]    index;
    logic [tsa_pkg::ELEM_PORT_W-1:0] value;
    logic                            we;
    logic                            err;
    logic                            last;
  } beat_t;

  // configuration registers
  logic [tsa_pkg::RANK_BITS-1:0] rank;
  logic [tsa_pkg::REG_BITS-1:0]  slice_shape;
  logic [tsa_pkg::REG_BITS-1:0]  full_shape;
  logic [tsa_pkg::REG_BITS-1:0]  offset;
  logic [tsa_pkg::REG_BITS-1:0]  extent;
  logic                          cfg_hit;

  logic [DIM_BITS-1:0] s_lane [MAX_RANK];
  logic [DIM_BITS-1:0] f_lane [MAX_RANK];
  logic [DIM_BITS-1:0] b_lane [MAX_RANK];
  logic [DIM_BITS-1:0] z_lane [MAX_RANK];

  tsa_pkg::setup_status_t        status;
  logic [tsa_pkg::IDX_BITS-1:0]  base;
  logic [tsa_pkg::IDX_BITS-1:0]  delta [MAX_RANK];

  // walk state
  logic [DIM_BITS-1:0]           cnt      [MAX_RANK];
  logic [DIM_BITS-1:0]           cnt_next [MAX_RANK];
  logic [tsa_pkg::IDX_BITS-1:0]  cur_idx;
  logic [tsa_pkg::IDX_BITS-1:0]  idx_next;
  logic                          last;

  // output stage
  logic  out_valid;
  logic  skid_valid;
  beat_t out_beat;
  beat_t skid_beat;
  beat_t res;
  logic  accept;

  always_comb begin
    unique case (cfg_index)
      tsa_pkg::CFG_RANK, tsa_pkg::CFG_SLICE_SHAPE, tsa_pkg::CFG_FULL_SHAPE,
      tsa_pkg::CFG_OFFSET, tsa_pkg::CFG_EXTENT: cfg_hit = cfg_we;
      default:                                  cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank        <= tsa_pkg::RANK_BITS'(1);
      slice_shape <= '0;
      full_shape  <= '0;
      offset      <= '0;
      extent      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tsa_pkg::CFG_RANK:        rank        <= cfg_data[tsa_pkg::RANK_BITS-1:0];
        tsa_pkg::CFG_SLICE_SHAPE: slice_shape <= cfg_data;
        tsa_pkg::CFG_FULL_SHAPE:  full_shape  <= cfg_data;
        tsa_pkg::CFG_OFFSET:      offset      <= cfg_data;
        tsa_pkg::CFG_EXTENT:      extent      <= cfg_data;
        default: ;
      endcase
    end
  end

  // lanes that lie above bit 63 read as zero
  for (genvar g = 0; g < MAX_RANK; g++) begin : g_lane
    if (g * DIM_BITS >= 64) begin : g_zero
      assign s_lane[g] = '0;
      assign f_lane[g] = '0;
      assign b_lane[g] = '0;
      assign z_lane[g] = '0;
    end else begin : g_field
      assign s_lane[g] = DIM_BITS'(slice_shape >> (g * DIM_BITS));
      assign f_lane[g] = DIM_BITS'(full_shape >> (g * DIM_BITS));
      assign b_lane[g] = DIM_BITS'(offset >> (g * DIM_BITS));
      assign z_lane[g] = DIM_BITS'(extent >> (g * DIM_BITS));
    end
  end

  tsa_setup #(
    .MAX_RANK (MAX_RANK),
    .DIM_BITS (DIM_BITS)
  ) u_setup (
    .clk    (clk),
    .rst    (rst),
    .start  (cfg_hit),
    .rank   (rank),
    .s_lane (s_lane),
    .f_lane (f_lane),
    .b_lane (b_lane),
    .z_lane (z_lane),
    .status (status),
    .base   (base),
    .delta  (delta)
  );

  // Advance the multi-index, last dimension fastest, and step the output index
  always_comb begin
    logic                         carry;
    logic                         wrap;
    logic [tsa_pkg::IDX_BITS-1:0] step;
    carry = 1'b1;
    step  = '0;
    for (int d = MAX_RANK - 1; d >= 0; d--) begin
      wrap        = (cnt[d] + DIM_BITS'(1)) == s_lane[d];
      cnt_next[d] = cnt[d];
      if (int'(rank) > d) begin
        if (carry) begin
          if (wrap) begin
            cnt_next[d] = '0;
          end else begin
            cnt_next[d] = cnt[d] + DIM_BITS'(1);
            step        = delta[d];
          end
        end
        carry = carry & wrap;
      end
    end
    last     = carry;
    idx_next = carry ? base : cur_idx + step;
  end

  assign res.index = status.cfg_ok ? cur_idx : '0;
  assign res.value = s_axis_tdata & ELEM_MASK;
  assign res.we    = status.cfg_ok;
  assign res.err   = !status.cfg_ok;
  assign res.last  = status.cfg_ok & last;

  assign s_axis_tready = !skid_valid && !status.busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_idx <= '0;
      for (int d = 0; d < MAX_RANK; d++) begin
        cnt[d] <= '0;
      end
    end else if (cfg_hit) begin
      for (int d = 0; d < MAX_RANK; d++) begin
        cnt[d] <= '0;
      end
    end else if (status.busy) begin
      // hold the first element's index until setup finishes
      cur_idx <= base;
    end else if (accept && status.cfg_ok) begin
      cur_idx <= idx_next;
      for (int d = 0; d < MAX_RANK; d++) begin
        cnt[d] <= cnt_next[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_beat   <= skid_beat;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
        if (accept) begin
          out_beat <= res;
        end
      end
    end else if (accept) begin
      // park the beat while the output stalls
      skid_valid <= 1'b1;
      skid_beat  <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_beat.value, out_beat.index};
  assign m_axis_tuser  = {out_beat.err, out_beat.we};
  assign m_axis_tlast  = out_beat.last;

endmodule

FILE: hdl/tsa_setup.sv
// Setup sequencer: checks the configuration and precomputes the base index and the
// per-dimension index steps, with one shared 32 x DIM_BITS multiplier.
// Depends on tsa_pkg.
module tsa_setup #(
  parameter int MAX_RANK = 4,
  parameter int DIM_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [tsa_pkg::RANK_BITS-1:0]      rank,
  input  logic [DIM_BITS-1:0]                s_lane [MAX_RANK],
  input  logic [DIM_BITS-1:0]                f_lane [MAX_RANK],
  input  logic [DIM_BITS-1:0]                b_lane [MAX_RANK],
  input  logic [DIM_BITS-1:0]                z_lane [MAX_RANK],
  output tsa_pkg::setup_status_t             status,
  output logic [tsa_pkg::IDX_BITS-1:0]       base,
  output logic [tsa_pkg::IDX_BITS-1:0]       delta [MAX_RANK]
);

  localparam int DW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam logic [DW-1:0] TOP_DIM = DW'(MAX_RANK - 1);
  localparam int PW = 32 + DIM_BITS;

  typedef enum logic [2:0] {
    PH_SLO, PH_SHI, PH_BLO, PH_BHI, PH_FLO, PH_FHI, PH_DRAIN, PH_NEXT
  } phase_t;

  logic                          busy;
  logic                          ok;
  logic [DW-1:0]                 d;
  phase_t                        phase;
  logic [tsa_pkg::IDX_BITS-1:0]  st;
  logic [tsa_pkg::IDX_BITS-1:0]  st_acc;
  logic [tsa_pkg::IDX_BITS-1:0]  w_acc;
  logic [tsa_pkg::IDX_BITS-1:0]  prod;
  phase_t                        ptag;
  logic                          pvalid;

  logic                          active;
  logic                          ok_next;
  logic [DIM_BITS-1:0]           op_lane;
  logic [31:0]                   op_half;
  logic [PW-1:0]                 p;
  logic [tsa_pkg::IDX_BITS-1:0]  addend;

  assign active = int'(rank) > int'(d);

  // Configuration check, one lane per dimension in use
  always_comb begin
    logic [DIM_BITS-1:0] z_eff;
    logic [DIM_BITS:0]   end_pos;
    ok_next = (rank != '0) && (int'(rank) <= MAX_RANK);
    for (int i = 0; i < MAX_RANK; i++) begin
      z_eff   = (z_lane[i] == '1) ? f_lane[i] - b_lane[i] : z_lane[i];
      end_pos = {1'b0, b_lane[i]} + {1'b0, z_eff};
      if (int'(rank) > i) begin
        if (s_lane[i] == '0 || s_lane[i] > f_lane[i] || b_lane[i] >= f_lane[i] ||
            z_eff != s_lane[i] || end_pos > {1'b0, f_lane[i]}) begin
          ok_next = 1'b0;
        end
      end
    end
  end

  // Operand selection for the shared multiplier
  always_comb begin
    unique case (phase)
      PH_SLO, PH_SHI: op_lane = s_lane[d] - DIM_BITS'(1);
      PH_BLO, PH_BHI: op_lane = b_lane[d];
      PH_FLO, PH_FHI: op_lane = f_lane[d];
      default:        op_lane = '0;
    endcase
    if (phase == PH_SHI || phase == PH_BHI || phase == PH_FHI) begin
      op_half = st[63:32];
    end else begin
      op_half = st[31:0];
    end
  end

  assign p = PW'(op_half) * PW'(op_lane);

  assign addend = (ptag == PH_SHI || ptag == PH_BHI || ptag == PH_FHI) ?
                  {prod[31:0], 32'b0} : prod;

  always_ff @(posedge clk) begin
    if (rst || start) begin
      busy   <= 1'b1;
      ok     <= 1'b0;
      d      <= TOP_DIM;
      phase  <= PH_SLO;
      st     <= 64'd1;
      st_acc <= '0;
      w_acc  <= '0;
      base   <= '0;
      pvalid <= 1'b0;
    end else begin
      ok     <= ok_next;
      pvalid <= 1'b0;
      if (pvalid) begin
        unique case (ptag)
          PH_SLO, PH_SHI: w_acc  <= w_acc + addend;
          PH_BLO, PH_BHI: base   <= base + addend;
          PH_FLO, PH_FHI: st_acc <= st_acc + addend;
          default: ;
        endcase
      end
      if (busy) begin
        if (!active) begin
          // skip dimensions above the rank
          if (d == '0) begin
            busy <= 1'b0;
          end else begin
            d <= d - DW'(1);
          end
        end else begin
          if (phase == PH_SLO) begin
            delta[d] <= st - w_acc;
          end
          if (phase <= PH_FHI) begin
            prod   <= 64'(p);
            ptag   <= phase;
            pvalid <= 1'b1;
          end
          if (phase == PH_NEXT) begin
            st     <= st_acc;
            st_acc <= '0;
            phase  <= PH_SLO;
            if (d == '0) begin
              busy <= 1'b0;
            end else begin
              d <= d - DW'(1);
            end
          end else begin
            phase <= phase_t'(phase + 3'd1);
          end
        end
      end
    end
  end

  assign status.busy   = busy;
  assign status.cfg_ok = ok;

endmodule
